// File: rtl/core/aabbcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabbcr_pkg
// Shared types, widths and helpers of the box collision resolver.
// ----------------------------------------------------------------------------
package aabbcr_pkg;

    // Default table depth
    localparam int MAX_BOXES_DEF = 64;

    // Field widths
    localparam int ID_W    = 6;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int VEL_W   = 16;
    // Working width of positions: 16-bit edge plus or minus a 15-bit size,
    // plus another size in the overlap compares
    localparam int POS_W   = 19;

    // Stream widths
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_RES_V  = 3'd2,
        CMD_RES_H  = 3'd3,
        CMD_GROUND = 3'd4
    } t_cmd;

    // One stored box
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIZE_W-1:0]  w;
        logic        [SIZE_W-1:0]  h;
    } t_box;

    // Moving box travelling down the cell chain
    typedef struct packed {
        logic                      valid;
        t_cmd                      cmd;
        logic        [ID_W-1:0]    id;
        logic signed [POS_W-1:0]   ax;
        logic signed [POS_W-1:0]   ay;
        logic        [SIZE_W-1:0]  aw;
        logic        [SIZE_W-1:0]  ah;
        logic signed [VEL_W-1:0]   vx;
        logic signed [VEL_W-1:0]   vy;
        logic                      gr;
    } t_tok;

    // Table write request broadcast to the cells
    typedef struct packed {
        logic en;
        logic pos_only;
        t_box box;
    } t_wr;

    // Result item
    typedef struct packed {
        logic                      full;
        logic        [ID_W-1:0]    assigned_id;
        logic                      gr;
        logic signed [VEL_W-1:0]   vy;
        logic signed [VEL_W-1:0]   vx;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_res;

    // Clamp a working position to the 16-bit field range
    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(17'sd32767);
        lo = -POS_W'(17'sd32768);
        if (v > hi) begin
            sat16 = COORD_W'(hi);
        end else if (v < lo) begin
            sat16 = COORD_W'(lo);
        end else begin
            sat16 = COORD_W'(v);
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/aabbcr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabbcr_cell
// One table entry: holds a box, tests the passing moving box against it and
// hands the updated moving box to the next cell.
// ----------------------------------------------------------------------------
module aabbcr_cell
    import aabbcr_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_wr              i_wr,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok
);

    // Cells above the id range can never be the moving box itself
    localparam logic IN_ID_RANGE = (CELL_IDX < (1 << ID_W));

    t_box r_box;
    t_tok r_tok;
    t_tok n_tok;

    logic                    active;
    logic                    is_self;
    logic signed [POS_W-1:0] bx, by, bw, bh, aw, ah;
    logic signed [POS_W-1:0] a_right, a_bot, b_right, b_bot;
    logic                    ovl;
    logic                    gnd;

    assign active  = (CNT_W'(CELL_IDX) < i_count);
    assign is_self = IN_ID_RANGE && (i_tok.id == ID_W'(CELL_IDX));

    // Edges of both boxes at working width
    assign bx      = POS_W'(r_box.x);
    assign by      = POS_W'(r_box.y);
    assign bw      = POS_W'({1'b0, r_box.w});
    assign bh      = POS_W'({1'b0, r_box.h});
    assign aw      = POS_W'({1'b0, i_tok.aw});
    assign ah      = POS_W'({1'b0, i_tok.ah});
    assign a_right = i_tok.ax + aw;
    assign a_bot   = i_tok.ay + ah;
    assign b_right = bx + bw;
    assign b_bot   = by + bh;

    // Strict overlap, and ground contact with inclusive bottom bounds
    assign ovl = (a_bot > by) && (i_tok.ay < b_bot) && (a_right > bx) && (i_tok.ax < b_right);
    assign gnd = (a_bot >= by) && (i_tok.ax < b_right) && (a_right > bx)
              && (a_bot <= b_bot) && (i_tok.ay < by);

    // Resolve the moving box against this entry
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && active && !is_self) begin
            unique case (i_tok.cmd)
                CMD_RES_V: begin
                    if (ovl && (i_tok.vy > 16'sd0)) begin
                        n_tok.ay = by - ah;
                        n_tok.vy = '0;
                        n_tok.gr = 1'b1;
                    end else if (ovl && (i_tok.vy < 16'sd0)) begin
                        n_tok.ay = b_bot;
                        n_tok.vy = '0;
                    end
                end
                CMD_RES_H: begin
                    if (ovl && (i_tok.vx > 16'sd0)) begin
                        n_tok.ax = bx - aw;
                        n_tok.vx = '0;
                    end else if (ovl && (i_tok.vx < 16'sd0)) begin
                        n_tok.ax = b_right;
                        n_tok.vx = '0;
                    end
                end
                CMD_GROUND: begin
                    if (gnd) begin
                        n_tok.gr = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Moving box stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Stored entry, written by append or position update
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IDX_W'(CELL_IDX))) begin
            if (i_wr.pos_only) begin
                r_box.x <= i_wr.box.x;
                r_box.y <= i_wr.box.y;
            end else begin
                r_box <= i_wr.box;
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// File: rtl/core/aabb_collision_resolver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_collision_resolver_unit
// Box table with append, position update, vertical and horizontal resolve
// and ground-contact query.
// ----------------------------------------------------------------------------
// Each table entry lives in its own cell of a chain of MAX_BOXES cells. Append
// and position update results are registered at acceptance and ready in the
// next cycle. A resolve or query item walks the chain one cell per cycle and
// passes one launch stage, MAX_BOXES cells and one output register before its
// result is ready. One item is processed at a time: the next item is taken
// once the walk is done and the output register is free or being read. The
// table needs no clearing after reset; entries are only read below the box
// count.
module aabb_collision_resolver_unit
    import aabbcr_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // entry_id, pos_x, pos_y, size_w, size_h, vel_x, vel_y, grounded_in, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // new_x, new_y, new_vx, new_vy, grounded_out, assigned_id, table_full
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    // Input item fields
    t_cmd                      cmd;
    logic        [ID_W-1:0]    f_id;
    logic signed [COORD_W-1:0] f_x, f_y;
    logic        [SIZE_W-1:0]  f_w, f_h;
    logic signed [VEL_W-1:0]   f_vx, f_vy;
    logic                      f_gr;

    assign cmd  = t_cmd'(i_s_axis_tuser);
    assign f_id = i_s_axis_tdata[5:0];
    assign f_x  = i_s_axis_tdata[21:6];
    assign f_y  = i_s_axis_tdata[37:22];
    assign f_w  = i_s_axis_tdata[52:38];
    assign f_h  = i_s_axis_tdata[67:53];
    assign f_vx = i_s_axis_tdata[83:68];
    assign f_vy = i_s_axis_tdata[99:84];
    assign f_gr = i_s_axis_tdata[100];

    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_out_valid;
    t_res             r_out;
    t_tok             r_inj;

    logic             acc;
    logic             is_walk;
    logic             has_room;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] id_ext;
    logic             id_ok;
    t_wr              wr;
    logic [IDX_W-1:0] wr_idx;
    t_res             res_imm;
    t_tok             tok_last;
    t_tok             w_tok [MAX_BOXES+1];
    logic [MAX_BOXES:0] tok_vld;

    // Handshake
    assign o_s_axis_tready = !r_busy && (!r_out_valid || i_m_axis_tready);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign is_walk         = (cmd == CMD_RES_V) || (cmd == CMD_RES_H) || (cmd == CMD_GROUND);

    // Table write decode
    assign cnt_ext  = CMP_W'(r_count);
    assign id_ext   = CMP_W'(f_id);
    assign has_room = (r_count < CNT_W'(MAX_BOXES));
    assign id_ok    = (id_ext < cnt_ext);

    always_comb begin
        wr.en       = 1'b0;
        wr.pos_only = 1'b0;
        wr.box.x    = f_x;
        wr.box.y    = f_y;
        wr.box.w    = f_w;
        wr.box.h    = f_h;
        wr_idx      = cnt_ext[IDX_W-1:0];
        res_imm     = '0;
        unique case (cmd)
            CMD_APPEND: begin
                wr.en = acc && has_room;
                if (has_room) begin
                    res_imm.assigned_id = cnt_ext[ID_W-1:0];
                end else begin
                    res_imm.full = 1'b1;
                end
            end
            CMD_UPDATE: begin
                wr.en       = acc && id_ok;
                wr.pos_only = 1'b1;
                wr_idx      = id_ext[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Box count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc && (cmd == CMD_APPEND) && has_room) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Launch stage of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj <= '0;
        end else begin
            r_inj.valid <= acc && is_walk;
            r_inj.cmd   <= cmd;
            r_inj.id    <= f_id;
            r_inj.ax    <= POS_W'(f_x);
            r_inj.ay    <= POS_W'(f_y);
            r_inj.aw    <= f_w;
            r_inj.ah    <= f_h;
            r_inj.vx    <= f_vx;
            r_inj.vy    <= f_vy;
            r_inj.gr    <= (cmd == CMD_GROUND) ? 1'b0 : f_gr;
        end
    end

    // Cell chain
    assign w_tok[0] = r_inj;

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        aabbcr_cell #(
            .CELL_IDX (k),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (wr),
            .i_wr_idx (wr_idx),
            .i_count  (r_count),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    for (genvar k = 0; k <= MAX_BOXES; k++) begin : g_vld
        assign tok_vld[k] = w_tok[k].valid;
    end

    assign tok_last = w_tok[MAX_BOXES];

    // Busy while a moving box is in the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (acc && is_walk) begin
            r_busy <= 1'b1;
        end else if (tok_last.valid) begin
            r_busy <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc && !is_walk) begin
            r_out_valid <= 1'b1;
        end else if (tok_last.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !is_walk) begin
            r_out <= res_imm;
        end else if (tok_last.valid) begin
            r_out.x           <= sat16(tok_last.ax);
            r_out.y           <= sat16(tok_last.ay);
            r_out.vx          <= tok_last.vx;
            r_out.vy          <= tok_last.vy;
            r_out.gr          <= tok_last.gr;
            r_out.assigned_id <= '0;
            r_out.full        <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Checks
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vld))
        else $error("more than one moving box in the chain");

    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_vld != '0) |-> r_busy)
        else $error("moving box in the chain while not busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_last.valid |-> !r_out_valid)
        else $error("chain result with output register still full");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table depth");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (cmd == CMD_APPEND) && !has_room) |=> $stable(r_count))
        else $error("append into a full table changed the count");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the box collision resolver. Items go in on the
// slave stream. A model of the box table held in the bench predicts every
// result item, and each result is checked field by field against the oldest
// prediction. Directed cases cover snapping, ground contact bounds,
// saturation and skipped ids. Bursty random traffic works on a crowded table,
// and both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import aabbcr_pkg::*;

    localparam int NBOX          = MAX_BOXES_DEF;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = NBOX + 8;
    localparam int MAX_REPORTS   = 40;
    // commands past the grounded query do nothing
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // one item on the slave stream
    typedef struct {
        logic [2:0]                cmd;
        logic        [ID_W-1:0]    id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIZE_W-1:0]  w;
        logic        [SIZE_W-1:0]  h;
        logic signed [VEL_W-1:0]   vx;
        logic signed [VEL_W-1:0]   vy;
        logic                      gr;
    } motion_req_t;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } shape_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // entry_id, pos_x, pos_y, size_w, size_h, vel_x, vel_y, grounded_in, zero pad
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // command
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // new_x, new_y, new_vx, new_vy, grounded_out, assigned_id, table_full
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // box table as the bench sees it
    shape_t boxes[NBOX];
    int     box_cnt = 0;
    t_res   outcome_q[$];

    // traffic shaping
    bit       tx_bursty = 1'b1;
    int       burst_left = 0;
    rx_mode_e rx_mode = RX_RANDOM;
    int       rx_pct = 70;
    int       rx_phase = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    // run statistics
    int n_items = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_snaps = 0;
    int n_contacts = 0;
    int n_full = 0;
    int n_clamped = 0;

    aabb_collision_resolver_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic int urand(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // mostly a small arena so boxes collide, sometimes anywhere
    function automatic int rand_coord();
        if (urand(0, 99) < 85) begin
            return urand(-320, 320);
        end
        return urand(-32768, 32767);
    endfunction

    function automatic int rand_size();
        int sel;
        sel = urand(0, 99);
        if (sel < 8) begin
            return 0;
        end else if (sel < 20) begin
            return urand(0, 32767);
        end
        return urand(1, 200);
    endfunction

    // only the sign matters to the block, the magnitude still toggles bits
    function automatic int rand_vel();
        int mag;
        mag = (urand(0, 1) == 0) ? urand(1, 15) : urand(1, 32767);
        case (urand(0, 2))
            0: return 0;
            1: return mag;
            default: return -mag - urand(0, 1);
        endcase
    endfunction

    function automatic motion_req_t make_req(input logic [2:0] cmd, input int id,
                                             input int x, input int y, input int w,
                                             input int h, input int vx, input int vy,
                                             input logic gr);
        motion_req_t r;
        r.cmd = cmd;
        r.id  = ID_W'(id);
        r.x   = COORD_W'(x);
        r.y   = COORD_W'(y);
        r.w   = SIZE_W'(w);
        r.h   = SIZE_W'(h);
        r.vx  = VEL_W'(vx);
        r.vy  = VEL_W'(vy);
        r.gr  = gr;
        return r;
    endfunction

    // Mostly aimed at a stored box so resolves and queries find contact
    function automatic motion_req_t make_random_req();
        motion_req_t r;
        shape_t      b;
        int          grow_w;
        int          pick;
        int          tgt;
        int          mw;
        int          mh;
        bit          aimed;
        grow_w = (box_cnt < NBOX) ? 16 : 4;
        pick   = urand(0, grow_w + 92);
        aimed  = (box_cnt > 0) && (urand(0, 99) < 75);
        tgt    = (box_cnt > 0) ? urand(0, box_cnt - 1) : 0;
        b      = boxes[tgt];
        r = make_req(CMD_APPEND, urand(0, 63), rand_coord(), rand_coord(), rand_size(),
                     rand_size(), rand_vel(), rand_vel(), urand(0, 1));
        if (pick < grow_w) begin
            return r;
        end
        pick -= grow_w;
        // position update, often next to another box
        if (pick < 16) begin
            r.cmd = CMD_UPDATE;
            if (box_cnt > 0 && urand(0, 99) < 85) begin
                r.id = ID_W'(urand(0, box_cnt - 1));
            end
            if (aimed) begin
                r.x = COORD_W'(b.x + urand(-64, 64));
                r.y = COORD_W'(b.y + urand(-64, 64));
            end
            return r;
        end
        pick -= 16;
        if (pick >= 74) begin
            r.cmd = 3'(CMD_SPARE_FIRST + urand(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
            return r;
        end
        r.cmd = (pick < 26) ? CMD_RES_V : (pick < 52) ? CMD_RES_H : CMD_GROUND;
        if (!aimed) begin
            return r;
        end
        if (urand(0, 99) < 80) begin
            mw = urand(1, 64);
            mh = urand(1, 64);
        end else begin
            mw = r.w;
            mh = r.h;
        end
        r.w = SIZE_W'(mw);
        r.h = SIZE_W'(mh);
        r.x = COORD_W'(b.x - mw + urand(1, (b.w + mw > 1) ? b.w + mw - 1 : 1));
        if (r.cmd == CMD_GROUND) begin
            // bottom edge within the blocker's top band, now and then one off
            r.y = COORD_W'(b.y - mh + urand(0, b.h) +
                           ((urand(0, 9) == 0) ? urand(-1, 1) : 0));
        end else begin
            r.y = COORD_W'(b.y - mh + urand(1, (b.h + mh > 1) ? b.h + mh - 1 : 1));
        end
        if (urand(0, 99) < 40) begin
            r.id = ID_W'(tgt);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return COORD_W'(v);
    endfunction

    function automatic bit boxes_overlap(input int ax, input int ay, input int aw,
                                         input int ah, input shape_t b);
        return (ay + ah > b.y) && (ay < b.y + b.h) && (ax + aw > b.x) && (ax < b.x + b.w);
    endfunction

    // Applies one item to the bench's table and returns the result it causes
    function automatic t_res compute_outcome(input motion_req_t r);
        t_res   res;
        shape_t b;
        int     ax;
        int     ay;
        int     aw;
        int     ah;
        int     vx;
        int     vy;
        int     bot;
        logic   gr;
        res = '0;
        ax  = r.x;
        ay  = r.y;
        aw  = r.w;
        ah  = r.h;
        vx  = r.vx;
        vy  = r.vy;
        gr  = r.gr;
        case (r.cmd)
            CMD_APPEND: begin
                if (box_cnt < NBOX) begin
                    boxes[box_cnt]  = '{ax, ay, aw, ah};
                    res.assigned_id = ID_W'(box_cnt);
                    box_cnt++;
                end else begin
                    res.full = 1'b1;
                    n_full++;
                end
            end
            CMD_UPDATE: begin
                // absent entries are left alone, size is kept
                if (r.id < box_cnt) begin
                    boxes[r.id].x = ax;
                    boxes[r.id].y = ay;
                end
            end
            CMD_RES_V, CMD_RES_H, CMD_GROUND: begin
                if (r.cmd == CMD_GROUND) begin
                    gr = 1'b0;
                end
                // walk in id order; later entries see the moved box
                for (int i = 0; i < box_cnt; i++) begin
                    if (i == r.id) begin
                        continue;
                    end
                    b = boxes[i];
                    if (r.cmd == CMD_GROUND) begin
                        bot = ay + ah;
                        if (ay < b.y && bot >= b.y && bot <= b.y + b.h &&
                            ax < b.x + b.w && ax + aw > b.x) begin
                            gr = 1'b1;
                            n_contacts++;
                            break;
                        end
                    end else if (boxes_overlap(ax, ay, aw, ah, b)) begin
                        if (r.cmd == CMD_RES_V && vy > 0) begin
                            ay = b.y - ah;
                            vy = 0;
                            gr = 1'b1;
                            n_snaps++;
                        end else if (r.cmd == CMD_RES_V && vy < 0) begin
                            ay = b.y + b.h;
                            vy = 0;
                            n_snaps++;
                        end else if (r.cmd == CMD_RES_H && vx > 0) begin
                            ax = b.x - aw;
                            vx = 0;
                            n_snaps++;
                        end else if (r.cmd == CMD_RES_H && vx < 0) begin
                            ax = b.x + b.w;
                            vx = 0;
                            n_snaps++;
                        end
                    end
                end
                if (ax > 32767 || ax < -32768 || ay > 32767 || ay < -32768) begin
                    n_clamped++;
                end
                res.x  = clamp16(ax);
                res.y  = clamp16(ay);
                res.vx = clamp16(vx);
                res.vy = clamp16(vy);
                res.gr = gr;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_req(input motion_req_t r);
        int gap;
        if (tx_bursty && burst_left == 0) begin
            gap        = urand(1, 12);
            burst_left = urand(1, 10);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, r.gr, r.vy, r.vx, r.h, r.w, r.y, r.x, r.id};
        i_s_axis_tuser  <= r.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        outcome_q.insert(outcome_q.size(), compute_outcome(r));
        n_items++;
    endtask

    // sender idles until every predicted result has come back
    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outcome_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("[%0t] result %0d: %s", $realtime, n_results, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_outcome(input t_res got);
        t_res want;
        if (outcome_q.size() == 0) begin
            report_mismatch("result item with no item pending");
        end else begin
            want = outcome_q.pop_front();
            check_field("new_x", got.x, want.x);
            check_field("new_y", got.y, want.y);
            check_field("new_vx", got.vx, want.vx);
            check_field("new_vy", got.vy, want.vy);
            check_field("grounded_out", got.gr, want.gr);
            check_field("assigned_id", got.assigned_id, want.assigned_id);
            check_field("table_full", got.full, want.full);
        end
        n_results++;
    endtask

    always @(posedge i_clk) begin
        rx_phase++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            check_outcome(t_res'(o_m_axis_tdata));
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_m_axis_tready <= 1'b1;
                RX_RANDOM: i_m_axis_tready <= (urand(0, 99) < rx_pct);
                default:   i_m_axis_tready <= ((rx_phase % 11) >= 4);
            endcase
        end
    end

    // watchdog on cycles where neither stream moves an item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results pending",
                     STALL_LIMIT, outcome_q.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // walks and updates before anything is stored
    task automatic test_empty_table();
        send_req(make_req(CMD_RES_V, 0, 16, 16, 32, 32, 3, 5, 1'b0));
        send_req(make_req(CMD_GROUND, 5, -16, 40, 8, 8, -2, 0, 1'b1));
        send_req(make_req(CMD_UPDATE, 0, 100, 100, 0, 0, 0, 0, 1'b0));
    endtask

    // floor box, two huge corner boxes and a zero-sized one, then snaps
    task automatic test_resolve_snaps();
        send_req(make_req(CMD_APPEND, 0, 0, 320, 1600, 64, 0, 0, 1'b0));
        send_req(make_req(CMD_APPEND, 0, 32000, 32000, 32767, 32767, 0, 0, 1'b0));
        send_req(make_req(CMD_APPEND, 0, -32768, -32768, 0, 0, 0, 0, 1'b0));
        send_req(make_req(CMD_APPEND, 0, -32768, -32768, 32767, 32767, 0, 0, 1'b0));
        // land on the floor, hit its underside, then no vertical motion
        send_req(make_req(CMD_RES_V, 9, 16, 300, 32, 32, 1, 5, 1'b0));
        send_req(make_req(CMD_RES_V, 9, 16, 370, 32, 32, 0, -3, 1'b0));
        send_req(make_req(CMD_RES_V, 9, 16, 330, 32, 32, 0, 0, 1'b1));
        // push against both side walls of the floor
        send_req(make_req(CMD_RES_H, 9, -16, 330, 32, 16, 7, 4, 1'b1));
        send_req(make_req(CMD_RES_H, 9, 1590, 330, 32, 16, -2, 0, 1'b0));
        // own id is skipped even though it overlaps
        send_req(make_req(CMD_RES_V, 0, 16, 300, 32, 32, 0, 5, 1'b0));
        // snapped edges beyond the field range saturate
        send_req(make_req(CMD_RES_V, 9, 32700, 32700, 10, 10, 0, -1, 1'b0));
        send_req(make_req(CMD_RES_V, 9, -32000, -32000, 16, 32767, 0, 1, 1'b0));
        send_req(make_req(CMD_RES_H, 9, -32000, -32000, 32767, 16, 1, 0, 1'b0));
    endtask

    // ground contact counts both ends of the blocker's band
    task automatic test_ground_contact();
        send_req(make_req(CMD_GROUND, 9, 16, 288, 32, 32, 0, 0, 1'b0));
        send_req(make_req(CMD_GROUND, 9, 16, 300, 32, 84, 0, 0, 1'b0));
        send_req(make_req(CMD_GROUND, 9, 16, 300, 32, 85, 0, 0, 1'b1));
    endtask

    task automatic test_update_and_spare();
        send_req(make_req(CMD_UPDATE, 2, 100, 100, 5, 5, 0, 0, 1'b0));
        send_req(make_req(CMD_UPDATE, 10, 200, 200, 0, 0, 0, 0, 1'b0));
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            send_req(make_req(3'(c), 1, -1, -1, 32767, 32767, -1, -1, 1'b1));
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_mode   = RX_ALWAYS;
        hold_left = 300;
        repeat (12) send_req(make_random_req());
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int n_chunks, input int chunk_len);
        for (int chunk = 0; chunk < n_chunks; chunk++) begin
            tx_bursty = (chunk % 3 != 0);
            rx_mode   = rx_mode_e'(chunk % 3);
            rx_pct    = urand(25, 90);
            repeat (chunk_len) send_req(make_random_req());
            wait_results_done();
        end
    endtask

    task automatic test_table_full();
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        while (box_cnt < NBOX) begin
            send_req(make_req(CMD_APPEND, 0, rand_coord(), rand_coord(), rand_size(),
                              rand_size(), 0, 0, 1'b0));
        end
        repeat (3) begin
            send_req(make_req(CMD_APPEND, 63, rand_coord(), rand_coord(), rand_size(),
                              rand_size(), rand_vel(), rand_vel(), 1'b1));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_resolve_snaps();
        test_ground_contact();
        test_update_and_spare();
        wait_results_done();
        test_backpressure();
        test_random_traffic(10, 175);
        test_table_full();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        end
        $display("run covered %0d items, %0d results: %0d snaps, %0d ground contacts",
                 n_items, n_results, n_snaps, n_contacts);
        $display("%0d appends on a full table, %0d saturated positions, %0d mismatches",
                 n_full, n_clamped, n_errors);
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/aabbcr_pkg.sv
rtl/core/aabbcr_cell.sv
rtl/core/aabb_collision_resolver_unit.sv
tb/sv/testbench.sv
